// ===== rtl/dasl_pkg.sv =====
// Shared types, constants and the sine table for the delayed-attack sine LFO.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package dasl_pkg;

  // Input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DELAY  = 3'd0;
  localparam logic [2:0] CFG_ATTACK = 3'd1;
  localparam logic [2:0] CFG_PERIOD = 3'd2;
  localparam logic [2:0] CFG_OFFSET = 3'd3;
  localparam logic [2:0] CFG_END    = 3'd4;

  // Operand widths of the serial units
  localparam int DIV_W   = 17;  // dividend / quotient
  localparam int DVSR_W  = 8;   // divisor
  localparam int MCAND_W = 24;  // elapsed = accum >> 8
  localparam int MPLR_W  = 17;  // rate
  localparam int PROD_W  = 32;  // product, wraps

  localparam logic [DIV_W-1:0] RATE_NUM = 17'h10000;  // 1 << 16

  typedef enum logic [1:0] {
    STG_OFF     = 2'd0,
    STG_DELAY   = 2'd1,
    STG_ATTACK  = 2'd2,
    STG_SUSTAIN = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] clocks_passed;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] lfo_value;
    logic [1:0]        stage_now;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]  mplier;
  } mul_req_t;

  // First quadrant of round(255*sin), 65 points including the peak
  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255
  };

  // Full-wave sine, two's complement, -255..255
  function automatic logic [8:0] sine_rom(input logic [7:0] idx);
    logic [6:0] r;
    logic [6:0] i;
    logic [8:0] mag;
    r = {1'b0, idx[5:0]};
    i = idx[6] ? (7'd64 - r) : r;
    mag = {1'b0, QUARTER_SINE[i]};
    return idx[7] ? (~mag + 9'd1) : mag;
  endfunction

endpackage

// ===== rtl/dasl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on dasl_pkg.
module dasl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dasl_pkg::div_req_t          req,
  output logic                        done,
  output logic [dasl_pkg::DIV_W-1:0]  quot
);

  logic [dasl_pkg::DIV_W-1:0]  dq_r, dq_nxt;
  logic [dasl_pkg::DVSR_W-1:0] rem_r, rem_nxt;
  logic [dasl_pkg::DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [dasl_pkg::DVSR_W:0]   trial;
  logic                        fits;

  assign trial = {rem_r, dq_r[dasl_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr_r};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? 8'(trial - {1'b0, dvsr_r}) : trial[dasl_pkg::DVSR_W-1:0];
      dq_nxt  = {dq_r[dasl_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(dasl_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

// ===== rtl/dasl_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, product wraps at PROD_W.
// Depends on dasl_pkg.
module dasl_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dasl_pkg::mul_req_t           req,
  output logic                         done,
  output logic [dasl_pkg::PROD_W-1:0]  prod
);

  logic [dasl_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [dasl_pkg::PROD_W-1:0] mcand_r, mcand_nxt;
  logic [dasl_pkg::MPLR_W-1:0] mplier_r, mplier_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = {{(dasl_pkg::PROD_W - dasl_pkg::MCAND_W){1'b0}}, req.mcand};
      mplier_nxt = req.mplier;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[dasl_pkg::PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[dasl_pkg::MPLR_W-1:1]};
      cnt_nxt    = cnt_r + 5'd1;
      if (cnt_r == 5'(dasl_pkg::MPLR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/delayed_attack_sine_lfo_core.sv =====
// Delayed-attack sine LFO, top level: control sequencer, state and configuration.
// Depends on dasl_pkg, dasl_div and dasl_mul.
//
// One item in, one item out, one item in flight at a time. Start, stop, an
// unknown opcode, and ticks while disabled or in pre-delay pass through the
// execute and finish steps only. A tick in attack or sustain runs a
// bit-serial 17-step division for the rate (65536/period) and a 17-step
// serial multiply for elapsed*rate. A fade-in tick runs a second 17-step
// division for the scale on the shared serial divider. The result sits in an
// output register, so the next item is taken while the previous result waits
// for out_ready; a new result stalls in the last step until that register is
// free. Configuration writes are registered and are meant to happen only
// while no item is in flight.
module delayed_attack_sine_lfo_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dasl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dasl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [7:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RATE,
    ST_MUL,
    ST_SCALE,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  dasl_pkg::stage_t     stage_r, stage_nxt;
  logic [31:0]          accum_r, accum_nxt;
  logic [7:0]           value_r, value_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [15:0]          passed_r, passed_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dasl_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [7:0] delay_len_r, attack_len_r, period_len_r, phase_offset_r, end_phase_r;

  dasl_pkg::div_req_t           div_req;
  dasl_pkg::mul_req_t           mul_req;
  logic                         div_done, mul_done;
  logic [dasl_pkg::DIV_W-1:0]   div_quot;
  logic [dasl_pkg::PROD_W-1:0]  mul_prod;

  // datapath helpers
  logic [31:0] accum_sum;
  logic [23:0] elapsed;
  logic [23:0] phase_raw;
  logic [7:0]  phase_cl;
  logic [7:0]  rom_idx;
  logic [8:0]  sine_full;
  logic [7:0]  sine_half;
  logic [7:0]  mag;
  logic [15:0] scaled;
  logic [7:0]  quot8;

  dasl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  dasl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign accum_sum = accum_r + {16'b0, passed_r};
  assign elapsed   = accum_r[31:8];

  // phase = (elapsed*rate mod 2^32) >> 8, capped when end_phase is set
  assign phase_raw = mul_prod[31:8];
  assign phase_cl  = (end_phase_r != 8'd0 && phase_raw > {16'b0, end_phase_r}) ?
                     end_phase_r : phase_raw[7:0];
  assign rom_idx   = phase_cl + phase_offset_r;
  assign sine_full = dasl_pkg::sine_rom(rom_idx);
  assign sine_half = sine_full[8:1];  // arithmetic >>1, already within -128..127
  assign mag       = sine_half[7] ? (~sine_half + 8'd1) : sine_half;
  assign scaled    = 16'(mag) * 16'(elapsed[7:0]);
  assign quot8     = div_quot[7:0];

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    accum_nxt     = accum_r;
    value_nxt     = value_r;
    op_nxt        = op_r;
    passed_nxt    = passed_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req       = '0;
    mul_req       = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          passed_nxt = in_data.clocks_passed;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
        case (op_r)
          dasl_pkg::OP_START: begin
            stage_nxt = dasl_pkg::STG_DELAY;
            accum_nxt = '0;
            value_nxt = '0;
          end
          dasl_pkg::OP_STOP: begin
            stage_nxt = dasl_pkg::STG_OFF;
            accum_nxt = '0;
            value_nxt = '0;
          end
          dasl_pkg::OP_TICK: begin
            case (stage_r)
              dasl_pkg::STG_OFF: value_nxt = '0;
              dasl_pkg::STG_DELAY: begin
                value_nxt = '0;
                if (accum_sum[31:8] >= {16'b0, delay_len_r}) begin
                  accum_nxt = '0;
                  stage_nxt = dasl_pkg::STG_ATTACK;
                end else begin
                  accum_nxt = accum_sum;
                end
              end
              default: begin
                // attack or sustain: rate = 65536 / period (period 0 acts as 1)
                accum_nxt        = accum_sum;
                div_req.start    = 1'b1;
                div_req.dividend = dasl_pkg::RATE_NUM;
                div_req.divisor  = (period_len_r == 8'd0) ? 8'd1 : period_len_r;
                state_nxt        = ST_RATE;
              end
            endcase
          end
          default: ;  // unknown opcode: state untouched, report as is
        endcase
      end
      ST_RATE: begin
        if (div_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = elapsed;
          mul_req.mplier = div_quot;
          state_nxt      = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (stage_r == dasl_pkg::STG_ATTACK && elapsed < {16'b0, attack_len_r}) begin
            // fade-in: |v|*elapsed/attack, sign restored afterward
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, scaled};
            div_req.divisor  = attack_len_r;
            neg_nxt          = sine_half[7];
            state_nxt        = ST_SCALE;
          end else begin
            if (stage_r == dasl_pkg::STG_ATTACK) stage_nxt = dasl_pkg::STG_SUSTAIN;
            value_nxt = sine_half;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          value_nxt = neg_r ? (~quot8 + 8'd1) : quot8;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.lfo_value = value_r;
          out_data_nxt.stage_now = stage_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    passed_r   <= passed_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      stage_r        <= dasl_pkg::STG_OFF;
      accum_r        <= '0;
      value_r        <= '0;
      out_valid_r    <= 1'b0;
      delay_len_r    <= 8'd0;
      attack_len_r   <= 8'd0;
      period_len_r   <= 8'd1;
      phase_offset_r <= 8'd0;
      end_phase_r    <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      accum_r     <= accum_nxt;
      value_r     <= value_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          dasl_pkg::CFG_DELAY:  delay_len_r    <= cfg_wdata;
          dasl_pkg::CFG_ATTACK: attack_len_r   <= cfg_wdata;
          dasl_pkg::CFG_PERIOD: period_len_r   <= cfg_wdata;
          dasl_pkg::CFG_OFFSET: phase_offset_r <= cfg_wdata;
          dasl_pkg::CFG_END:    end_phase_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one item in flight: an accept is never followed directly by another
  a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // disabled and pre-delay always report a zero output
  a_quiet_stages: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stage_now == dasl_pkg::STG_OFF ||
                  out_data.stage_now == dasl_pkg::STG_DELAY) |->
    out_data.lfo_value == 8'sd0)
    else $error("nonzero output in disabled or pre-delay stage");

  // the divider only finishes while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_RATE || state_r == ST_SCALE)
    else $error("divider result arrived outside a divide step");

  // the multiplier only finishes while the sequencer waits for it
  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier result arrived outside the multiply step");

endmodule

// ===== bench/tb.sv =====
// Testbench for delayed_attack_sine_lfo_core: directed and random streams of start, stop
// and tick items under several register settings, checked against an in-bench LFO predictor.
// Depends on dasl_pkg (types, opcodes, register indexes) and the core RTL.
module tb;

  // Opcode three is not decoded by the block: state holds, result repeats the last one
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int STALL_PCT      = 6;     // idle chance per decision, both sides
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES    = 80;    // extra cycles after the last result, before the summary
  localparam int SETTLE_CYCLES  = 4;

  // round(255*sin) over the first quadrant, peak included
  localparam logic [7:0] SINE_QUADRANT [65] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  dasl_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dasl_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_addr  = dasl_pkg::CFG_DELAY;
  logic [7:0]          cfg_wdata = 8'd0;

  // Predictor copy of the registers and state; reset values match the block
  logic [7:0]        reg_delay  = 8'd0;
  logic [7:0]        reg_attack = 8'd0;
  logic [7:0]        reg_period = 8'd1;
  logic [7:0]        reg_offset = 8'd0;
  logic [7:0]        reg_end    = 8'd0;
  dasl_pkg::stage_t  lfo_stage  = dasl_pkg::STG_OFF;
  logic [31:0]       lfo_accum  = '0;
  logic signed [7:0] lfo_held   = '0;

  dasl_pkg::out_item_t pending_outputs [$];

  bit       calm            = 1'b0;  // no idling on either side while set
  int       fail_count      = 0;
  int       items_sent      = 0;
  int       results_checked = 0;
  int       settings_used   = 0;
  int       idle_cycles     = 0;
  bit [3:0] stages_seen     = '0;

  delayed_attack_sine_lfo_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Full-wave table value, -255..255
  function automatic int sine_point(input logic [7:0] idx);
    int r;
    int mag;
    r = int'(idx[5:0]);
    mag = idx[6] ? int'(SINE_QUADRANT[64 - r]) : int'(SINE_QUADRANT[r]);
    return idx[7] ? -mag : mag;
  endfunction

  // Advances the predicted state by one item and returns the result it should produce
  function automatic dasl_pkg::out_item_t lfo_next(input dasl_pkg::in_item_t it);
    logic [31:0]         rate;
    logic [31:0]         elapsed;
    logic [31:0]         product;
    logic [31:0]         phase;
    logic [7:0]          idx;
    int                  v;
    dasl_pkg::out_item_t res;
    case (it.opcode)
      dasl_pkg::OP_TICK: begin
        if (lfo_stage == dasl_pkg::STG_OFF) begin
          lfo_held = '0;
        end else if (lfo_stage == dasl_pkg::STG_DELAY) begin
          // output stays silent, even on the tick that ends the pre-delay
          lfo_accum = lfo_accum + 32'(it.clocks_passed);
          lfo_held = '0;
          if ((lfo_accum >> 8) >= 32'(reg_delay)) begin
            lfo_accum = '0;
            lfo_stage = dasl_pkg::STG_ATTACK;
          end
        end else begin
          rate = 32'h10000 / 32'((reg_period == 8'd0) ? 8'd1 : reg_period);
          lfo_accum = lfo_accum + 32'(it.clocks_passed);
          elapsed = lfo_accum >> 8;
          product = elapsed * rate;  // wraps at 32 bits before the shift
          phase = product >> 8;
          if (reg_end != 8'd0 && phase > 32'(reg_end)) begin
            phase = 32'(reg_end);
          end
          idx = phase[7:0] + reg_offset;
          v = sine_point(idx) >>> 1;  // floor halving, lands in -128..127
          if (lfo_stage == dasl_pkg::STG_ATTACK) begin
            // fade-in scale truncates toward zero; the tick reaching attack_len is unscaled
            if (elapsed < 32'(reg_attack)) begin
              v = v * int'(elapsed) / int'(reg_attack);
            end else begin
              lfo_stage = dasl_pkg::STG_SUSTAIN;
            end
          end
          lfo_held = 8'(v);
        end
      end
      dasl_pkg::OP_START: begin
        lfo_stage = dasl_pkg::STG_DELAY;
        lfo_accum = '0;
        lfo_held = '0;
      end
      dasl_pkg::OP_STOP: begin
        lfo_stage = dasl_pkg::STG_OFF;
        lfo_accum = '0;
        lfo_held = '0;
      end
      default: begin
      end
    endcase
    stages_seen[lfo_stage] = 1'b1;
    res.lfo_value = lfo_held;
    res.stage_now = lfo_stage;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Called right after a rising edge; returns at the edge that accepted the item.
  // Valid is not lowered here, so back-to-back items keep it high.
  task automatic send_item(input logic [1:0] op, input logic [15:0] clocks);
    dasl_pkg::in_item_t it;
    it.opcode = op;
    it.clocks_passed = clocks;
    if (!calm && $urandom_range(99) < STALL_PCT) begin
      // gap of varying length so that it falls on different phases of the block's work
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outputs.push_back(lfo_next(it));
    items_sent++;
  endtask

  // Sender holds off until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Registers change only with the block idle
  task automatic program_regs(input logic [7:0] dly, input logic [7:0] atk,
                              input logic [7:0] per, input logic [7:0] ofs,
                              input logic [7:0] ceil_ph);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(dasl_pkg::CFG_DELAY, dly);
    write_reg(dasl_pkg::CFG_ATTACK, atk);
    write_reg(dasl_pkg::CFG_PERIOD, per);
    write_reg(dasl_pkg::CFG_OFFSET, ofs);
    write_reg(dasl_pkg::CFG_END, ceil_ph);
    cfg_we <= 1'b0;
    reg_delay = dly;
    reg_attack = atk;
    reg_period = per;
    reg_offset = ofs;
    reg_end = ceil_ph;
    settings_used++;
  endtask

  // Mostly short lengths so fade-in and pre-delay last a few ticks
  function automatic logic [7:0] pick_len();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
  endfunction

  task automatic program_random();
    logic [7:0] ceil_ph;
    ceil_ph = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255));
    program_regs(pick_len(), pick_len(), 8'($urandom_range(1, 255)),
                 8'($urandom_range(255)), ceil_ph);
  endtask

  function automatic logic [15:0] pick_clocks();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1023));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // A start followed by mostly ticks, with a few stops, restarts and ignored opcodes
  task automatic run_session(input int n);
    int pick;
    send_item(dasl_pkg::OP_START, 16'($urandom_range(65535)));
    repeat (n - 1) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(dasl_pkg::OP_STOP, 16'($urandom_range(65535)));
      end else if (pick < 8) begin
        send_item(dasl_pkg::OP_START, 16'($urandom_range(65535)));
      end else if (pick < 11) begin
        send_item(OP_IGNORED, 16'($urandom_range(65535)));
      end else begin
        send_item(dasl_pkg::OP_TICK, pick_clocks());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: every opcode, ignored opcode in off and sustain, field extremes
  task automatic test_reset_and_ops();
    send_item(OP_IGNORED, 16'hFFFF);
    send_item(dasl_pkg::OP_TICK, 16'hFFFF);     // tick while disabled
    send_item(dasl_pkg::OP_STOP, 16'h0000);
    send_item(dasl_pkg::OP_START, 16'hAAAA);
    send_item(dasl_pkg::OP_TICK, 16'h0000);     // zero delay: straight to attack, still silent
    send_item(dasl_pkg::OP_TICK, 16'h5555);     // zero attack length: straight to sustain
    send_item(OP_IGNORED, 16'h0000);
    send_item(dasl_pkg::OP_TICK, 16'hFFFF);
    send_item(dasl_pkg::OP_START, 16'h0000);    // restart out of sustain
    send_item(dasl_pkg::OP_STOP, 16'h0000);
  endtask

  // Step through pre-delay and fade-in one unit at a time; negative half of the sine
  // exercises truncation toward zero, then a ceiling on the phase
  task automatic test_stage_walk();
    program_regs(8'd2, 8'd4, 8'd255, 8'd128, 8'd0);
    send_item(dasl_pkg::OP_START, 16'h0000);
    repeat (8) send_item(dasl_pkg::OP_TICK, 16'h0100);
    send_item(dasl_pkg::OP_TICK, 16'h3FFF);
    program_regs(8'd0, 8'd255, 8'd7, 8'd255, 8'd3);
    send_item(dasl_pkg::OP_START, 16'h0000);
    send_item(dasl_pkg::OP_TICK, 16'h0000);
    send_item(dasl_pkg::OP_TICK, 16'h4000);
    send_item(dasl_pkg::OP_TICK, 16'hFFFF);
    send_item(dasl_pkg::OP_TICK, 16'hFFFF);
  endtask

  // Lowest and highest settings first, then random ones
  task automatic test_random_sessions();
    program_regs(8'd0, 8'd0, 8'd1, 8'd0, 8'd0);
    run_session(110);
    program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_session(110);
    repeat (4) begin
      program_random();
      run_session(110);
    end
  endtask

  // Sender stops mid-session until the block has answered everything
  task automatic test_drain_pause();
    program_random();
    run_session(40);
    wait_drained();
    repeat ($urandom_range(1, 20)) @(posedge clk);
    repeat (40) send_item(dasl_pkg::OP_TICK, pick_clocks());
  endtask

  // Long stretch with both sides always ready
  task automatic test_no_idling();
    program_random();
    calm = 1'b1;
    run_session(120);
    wait_drained();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  // Every accepted result is matched against the oldest prediction
  always @(posedge clk) begin
    dasl_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result with nothing expected: lfo_value %0d, stage_now %0d",
               out_data.lfo_value, out_data.stage_now);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_data.lfo_value !== want.lfo_value) begin
          $error("lfo_value: expected %0d, got %0d", want.lfo_value, out_data.lfo_value);
          fail_count++;
        end
        if (out_data.stage_now !== want.stage_now) begin
          $error("stage_now: expected %0d, got %0d", want.stage_now, out_data.stage_now);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  // Ends a hung run: counts cycles in which no item moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_outputs.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_ops();
    test_stage_walk();
    test_random_sessions();
    test_drain_pause();
    test_no_idling();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items over %0d register settings, %0d results compared.",
             items_sent, settings_used, results_checked);
    $display("Stages reached: off %0d, pre-delay %0d, attack %0d, sustain %0d.",
             stages_seen[0], stages_seen[1], stages_seen[2], stages_seen[3]);
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
